[hw/rtl/assert_macros.svh]
// assertion macros for the heap queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/imhq_pkg.sv]
// shared types and codes for the indexed min-heap queue
`timescale 1ns / 1ps
package imhq_pkg;
  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_EXTRACT = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_CHANGE  = 3'd3;
  localparam logic [2:0] OP_EXISTS  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_NOKEY   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_PRESENT = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         key;
    logic signed [31:0] priority_req;
  } imhq_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         out_key;
    logic signed [31:0] out_priority;
    logic               present;
  } imhq_out_t;
endpackage

[hw/rtl/imhq_heap_mem.sv]
// heap slot memory: key and priority per slot, one write and one read port
`timescale 1ns / 1ps
module imhq_heap_mem #(
  parameter int AW = 8,
  parameter int PW = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [7:0]           wkey,
  input  logic signed [PW-1:0] wprio,
  input  logic [AW-1:0]        raddr,
  output logic [7:0]           rkey,
  output logic signed [PW-1:0] rprio
);
  logic [8+PW-1:0] mem [0:(1<<AW)-1];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wkey, wprio};
    {rkey, rprio} <= mem[raddr];
  end
endmodule

[hw/rtl/imhq_pos_mem.sv]
// key position table, one write and one read port; the top clears it after reset
`timescale 1ns / 1ps
module imhq_pos_mem #(
  parameter int KW = 8,
  parameter int SW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [KW-1:0] waddr,
  input  logic [SW-1:0] wdata,
  input  logic [KW-1:0] raddr,
  output logic [SW-1:0] rdata
);
  logic [SW-1:0] mem [0:(1<<KW)-1];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/indexed_min_heap_queue_top.sv]
// indexed min-heap queue top: sequencer over heap and position memories
//
//  channel | dir | payload              | handshake
//  in_     | in  | imhq_pkg::imhq_in_t  | in_valid / in_ready
//  out_    | out | imhq_pkg::imhq_out_t | out_valid / out_ready
//
// one item at a time; exists, unknown ops, refusals and empty extract go from dispatch to done
// a sift-up level reads the parent, compares and swaps with two writes; a sift-down level
// reads both children, compares and swaps with two writes
// after reset a clearing pass writes one position entry per cycle (KEYS, at most 256)
// out_ holds one result register; a finished item waits in done while it is full
`timescale 1ns / 1ps
`include "assert_macros.svh"
module indexed_min_heap_queue_top #(
  parameter int CAPACITY = 256,
  parameter int KEYS = 256,
  parameter int PRIORITY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  imhq_pkg::imhq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output imhq_pkg::imhq_out_t out_data
);
  localparam int AW = $clog2(CAPACITY + 1);
  localparam int KW = (KEYS > 256) ? 8 : $clog2(KEYS);
  localparam int PW = PRIORITY_BITS;
  localparam int NCLR = (KEYS > 256) ? 256 : KEYS;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_POS   = 4'd2;
  localparam logic [3:0] S_DISP  = 4'd3;
  localparam logic [3:0] S_RDA   = 4'd4;
  localparam logic [3:0] S_RDB   = 4'd5;
  localparam logic [3:0] S_UPCMP = 4'd6;
  localparam logic [3:0] S_DNL   = 4'd7;
  localparam logic [3:0] S_DNR   = 4'd8;
  localparam logic [3:0] S_DNCMP = 4'd9;
  localparam logic [3:0] S_SWP   = 4'd10;
  localparam logic [3:0] S_TOP   = 4'd11;
  localparam logic [3:0] S_LAST  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;
  localparam logic [3:0] S_CHG   = 4'd14;

  logic [3:0] st_r, st_nxt;
  logic [2:0] op_r;
  logic [7:0] key_r;
  logic signed [PW-1:0] prio_r;
  logic [AW-1:0] cnt_r, pos_r, oth_r;
  logic signed [PW-1:0] cur_p_r, oth_p_r, l_p_r;
  logic [7:0] cur_k_r, oth_k_r, l_k_r;
  logic force_r, up_r, swp2_r;
  logic [KW:0] clr_r;
  imhq_pkg::imhq_out_t res_r;
  imhq_pkg::imhq_out_t out_r;
  logic ov_r;

  logic hwe, pwe;
  logic [AW-1:0] hwa, hra;
  logic [7:0] hwk, hrk;
  logic signed [PW-1:0] hwp, hrp;
  logic [KW-1:0] pwa, pra;
  logic [AW-1:0] pwd, prd;

  imhq_heap_mem #(.AW(AW), .PW(PW)) u_heap (
    .clk(clk), .we(hwe), .waddr(hwa), .wkey(hwk), .wprio(hwp),
    .raddr(hra), .rkey(hrk), .rprio(hrp));
  imhq_pos_mem #(.KW(KW), .SW(AW)) u_pos (
    .clk(clk), .we(pwe), .waddr(pwa), .wdata(pwd),
    .raddr(pra), .rdata(prd));

  logic key_ok;
  logic signed [PW-1:0] prio_in;
  assign key_ok = (32'(key_r) < 32'(KEYS));
  assign prio_in = PW'(in_data.priority_req);
  assign in_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data = out_r;

  // signals of the state machine
  logic [AW-1:0] cnt_nxt, pos_nxt, oth_nxt;
  logic signed [PW-1:0] cur_p_nxt, oth_p_nxt, l_p_nxt;
  logic [7:0] cur_k_nxt, oth_k_nxt, l_k_nxt;
  logic force_nxt, up_nxt, swp2_nxt;
  imhq_pkg::imhq_out_t res_nxt;
  logic fin;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; pos_nxt = pos_r; oth_nxt = oth_r;
    cur_p_nxt = cur_p_r; oth_p_nxt = oth_p_r; l_p_nxt = l_p_r;
    cur_k_nxt = cur_k_r; oth_k_nxt = oth_k_r; l_k_nxt = l_k_r;
    force_nxt = force_r; up_nxt = up_r; swp2_nxt = swp2_r;
    res_nxt = res_r; fin = 1'b0;
    hwe = 1'b0; hwa = pos_r; hwk = cur_k_r; hwp = cur_p_r; hra = pos_r;
    pwe = 1'b0; pwa = cur_k_r[KW-1:0]; pwd = pos_r; pra = in_data.key[KW-1:0];
    case (st_r)
      S_CLR: begin
        pwe = 1'b1; pwa = clr_r[KW-1:0]; pwd = '0;
        if (clr_r == (KW+1)'(NCLR - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        pra = in_data.key[KW-1:0];
        if (in_valid && in_ready) begin
          res_nxt = '0;
          st_nxt = S_POS;
        end
      end
      S_POS: begin
        st_nxt = S_DISP;
        hra = prd;
        pos_nxt = key_ok ? prd : '0;
      end
      S_DISP: begin
        res_nxt.present = (pos_r != '0);
        case (op_r)
          imhq_pkg::OP_INSERT: begin
            if (!key_ok) begin
              res_nxt.status = imhq_pkg::ST_NOKEY; st_nxt = S_DONE;
            end else if (pos_r != '0) begin
              res_nxt.status = imhq_pkg::ST_PRESENT; st_nxt = S_DONE;
            end else if (32'(cnt_r) >= 32'(CAPACITY)) begin
              res_nxt.status = imhq_pkg::ST_FULL; st_nxt = S_DONE;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
              pos_nxt = cnt_r + 1'b1;
              cur_k_nxt = key_r; cur_p_nxt = prio_r; force_nxt = 1'b0;
              hwe = 1'b1; hwa = cnt_r + 1'b1; hwk = key_r; hwp = prio_r;
              pwe = 1'b1; pwa = key_r[KW-1:0]; pwd = cnt_r + 1'b1;
              st_nxt = S_RDA;
            end
          end
          imhq_pkg::OP_EXTRACT: begin
            if (cnt_r == '0) begin
              res_nxt.status = imhq_pkg::ST_EMPTY; res_nxt.present = 1'b0;
              st_nxt = S_DONE;
            end else begin
              res_nxt.present = 1'b1; hra = AW'(1); st_nxt = S_TOP;
            end
          end
          imhq_pkg::OP_DELETE: begin
            if (pos_r == '0) begin
              res_nxt.status = imhq_pkg::ST_NOKEY; st_nxt = S_DONE;
            end else begin
              cur_k_nxt = hrk; cur_p_nxt = hrp; force_nxt = 1'b1; st_nxt = S_RDA;
            end
          end
          imhq_pkg::OP_CHANGE: begin
            if (pos_r == '0) begin
              res_nxt.status = imhq_pkg::ST_NOKEY; st_nxt = S_DONE;
            end else begin
              cur_k_nxt = hrk; cur_p_nxt = prio_r; force_nxt = 1'b0;
              hwe = 1'b1; hwa = pos_r; hwk = hrk; hwp = prio_r;
              up_nxt = (prio_r < hrp);
              st_nxt = (prio_r < hrp) ? S_RDA : (prio_r > hrp) ? S_DNL : S_DONE;
            end
          end
          imhq_pkg::OP_EXISTS: st_nxt = S_DONE;
          default: begin res_nxt.present = 1'b0; st_nxt = S_DONE; end
        endcase
      end
      S_RDA: begin
        // sift up: read parent
        if (pos_r <= AW'(1)) begin
          st_nxt = (op_r == imhq_pkg::OP_DELETE) ? S_TOP : S_DONE;
          hra = AW'(1);
        end else begin
          oth_nxt = pos_r >> 1; hra = pos_r >> 1; st_nxt = S_UPCMP; up_nxt = 1'b1;
        end
      end
      S_UPCMP: begin
        if (force_r || hrp > cur_p_r) begin
          oth_k_nxt = hrk; oth_p_nxt = hrp; st_nxt = S_SWP; swp2_nxt = 1'b0;
        end else st_nxt = S_DONE;
      end
      S_SWP: begin
        // move other entry into pos, cur into oth
        if (!swp2_r) begin
          hwe = 1'b1; hwa = pos_r; hwk = oth_k_r; hwp = oth_p_r;
          pwe = 1'b1; pwa = oth_k_r[KW-1:0]; pwd = pos_r; swp2_nxt = 1'b1;
        end else begin
          hwe = 1'b1; hwa = oth_r; hwk = cur_k_r; hwp = cur_p_r;
          pwe = 1'b1; pwa = cur_k_r[KW-1:0]; pwd = oth_r;
          pos_nxt = oth_r; st_nxt = up_r ? S_RDA : S_DNL;
        end
      end
      S_TOP: begin
        // root read issued last cycle; pos_r irrelevant
        res_nxt.out_key = hrk; res_nxt.out_priority = 32'(hrp);
        pwe = 1'b1; pwa = hrk[KW-1:0]; pwd = '0;
        hra = cnt_r; st_nxt = S_LAST;
      end
      S_LAST: begin
        cnt_nxt = cnt_r - 1'b1;
        pos_nxt = AW'(1); up_nxt = 1'b0;
        if (cnt_r > AW'(1)) begin
          cur_k_nxt = hrk; cur_p_nxt = hrp;
          hwe = 1'b1; hwa = AW'(1); hwk = hrk; hwp = hrp;
          pwe = 1'b1; pwa = hrk[KW-1:0]; pwd = AW'(1);
          st_nxt = S_DNL;
        end else st_nxt = S_DONE;
      end
      S_DNL: begin
        if ({1'b0, pos_r} << 1 > {1'b0, cnt_r}) st_nxt = S_DONE;
        else begin
          hra = pos_r << 1; oth_nxt = pos_r << 1; st_nxt = S_DNR;
        end
      end
      S_DNR: begin
        l_k_nxt = hrk; l_p_nxt = hrp;
        hra = oth_r + 1'b1; st_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        oth_k_nxt = l_k_r; oth_p_nxt = l_p_r;
        if ((oth_r + 1'b1) <= cnt_r && oth_r != '1 && hrp < l_p_r) begin
          oth_nxt = oth_r + 1'b1; oth_k_nxt = hrk; oth_p_nxt = hrp;
        end
        if (cur_p_r > (((oth_r + 1'b1) <= cnt_r && oth_r != '1 && hrp < l_p_r)
            ? hrp : l_p_r)) begin
          st_nxt = S_SWP; swp2_nxt = 1'b0;
        end else st_nxt = S_DONE;
      end
      S_CHG: st_nxt = S_DONE;
      S_DONE: begin
        if (!ov_r || out_ready) fin = 1'b1;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (fin) st_nxt = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt;
      if (st_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (fin) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt; oth_r <= oth_nxt; cur_p_r <= cur_p_nxt; oth_p_r <= oth_p_nxt;
    l_p_r <= l_p_nxt; cur_k_r <= cur_k_nxt; oth_k_r <= oth_k_nxt; l_k_r <= l_k_nxt;
    force_r <= force_nxt; up_r <= up_nxt; swp2_r <= swp2_nxt; res_r <= res_nxt;
    if (fin) out_r <= res_r;
    if (st_r == S_IDLE && in_valid && in_ready) begin
      op_r <= in_data.op; key_r <= in_data.key; prio_r <= prio_in;
    end
  end

  `ASSERT_IMPL(a_cnt_cap, 1'b1, 32'(cnt_r) <= 32'(CAPACITY))
  `ASSERT_IMPL(a_no_accept_busy, (st_r != S_IDLE), !in_ready)
  `ASSERT_NEXT(a_done_valid, fin, out_valid)
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMPL(a_pwd_fit, pwe, 32'(pwd) <= 32'(CAPACITY))
endmodule
